>>> hdl/dbrt_pkg.sv
// shared types and control byte bit positions for the dual byte reload timer
`timescale 1ns / 1ps

package dbrt_pkg;

  // control byte bit positions
  localparam int unsigned BIT_RUN_HIGH = 7;
  localparam int unsigned BIT_RUN_LOW  = 6;
  localparam int unsigned BIT_MODE16   = 5;
  localparam int unsigned BIT_FLAG_HI  = 3;
  localparam int unsigned BIT_IE_HI    = 2;
  localparam int unsigned BIT_FLAG_LO  = 1;
  localparam int unsigned BIT_IE_LO    = 0;

  // item operation codes
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } dbrt_op_t;

  // configuration register indexes
  typedef enum logic {
    REG_LOW_RELOAD  = 1'b0,
    REG_HIGH_RELOAD = 1'b1
  } dbrt_reg_t;

  typedef struct packed {
    dbrt_op_t   op;
    logic [7:0] write_data;
    logic       prescale_pulse;
  } dbrt_item_t;

  typedef struct packed {
    logic [7:0] ctl;
    logic [7:0] lo;
    logic [7:0] hi;
    logic       low_running;
    logic       high_running;
  } dbrt_state_t;

  typedef struct packed {
    logic [7:0] low_count;
    logic [7:0] high_count;
    logic [7:0] control_out;
    logic       low_irq;
    logic       high_irq;
  } dbrt_result_t;

endpackage

>>> hdl/dbrt_if.sv
// channel interfaces: tick/write items, results and configuration writes
`timescale 1ns / 1ps

interface dbrt_in_if;
  logic             valid;
  logic             ready;
  dbrt_pkg::dbrt_op_t op;
  logic [7:0]       write_data;
  logic             prescale_pulse;
  modport source (output valid, op, write_data, prescale_pulse, input ready);
  modport sink   (input valid, op, write_data, prescale_pulse, output ready);
endinterface

interface dbrt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] low_count;
  logic [7:0] high_count;
  logic [7:0] control_out;
  logic       low_irq;
  logic       high_irq;
  modport source (output valid, low_count, high_count, control_out, low_irq, high_irq,
                  input ready);
  modport sink   (input valid, low_count, high_count, control_out, low_irq, high_irq,
                  output ready);
endinterface

interface dbrt_cfg_if;
  logic                valid;
  logic                ready;
  dbrt_pkg::dbrt_reg_t index;
  logic [7:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/dbrt_step.sv
// next-state and result logic for one timer item
`timescale 1ns / 1ps

module dbrt_step (
  input  dbrt_pkg::dbrt_item_t   item,
  input  dbrt_pkg::dbrt_state_t  state,
  input  logic [7:0]             low_reload,
  input  logic [7:0]             high_reload,
  output dbrt_pkg::dbrt_state_t  state_nxt,
  output dbrt_pkg::dbrt_result_t result
);

  always_comb begin
    logic [8:0] lo;
    logic [8:0] hi;
    logic [7:0] ctl;
    logic       mode16;
    logic       lrun;
    logic       hrun;
    logic       lirq;
    logic       hirq;

    ctl    = state.ctl;
    lo     = {1'b0, state.lo};
    hi     = {1'b0, state.hi};
    lrun   = state.low_running;
    hrun   = state.high_running;
    lirq   = 1'b0;
    hirq   = 1'b0;
    mode16 = ctl[dbrt_pkg::BIT_MODE16];

    if (item.op == dbrt_pkg::OP_WRITE) begin
      ctl = item.write_data;
    end else begin
      // low counter: load when stopped or on first enabled tick
      if (ctl[dbrt_pkg::BIT_RUN_LOW]) begin
        if (!lrun) begin
          lrun = 1'b1;
          lo   = {1'b0, low_reload};
        end else if (item.prescale_pulse) begin
          lo = lo + 9'd1;
        end
      end else begin
        lo   = {1'b0, low_reload};
        lrun = 1'b0;
      end

      // high counter: counts on the prescaler only in 8-bit mode
      if (ctl[dbrt_pkg::BIT_RUN_HIGH]) begin
        if (!hrun) begin
          hrun = 1'b1;
          hi   = {1'b0, high_reload};
        end else if (!mode16 && item.prescale_pulse) begin
          hi = hi + 9'd1;
        end
      end else begin
        hi   = {1'b0, high_reload};
        hrun = 1'b0;
      end

      if (lo[8]) begin
        if (!mode16) begin
          ctl[dbrt_pkg::BIT_FLAG_LO] = 1'b1;
        end else begin
          hi = hi + 9'd1;
        end
        lirq = ctl[dbrt_pkg::BIT_IE_LO];
        lo   = {1'b0, low_reload};
      end

      if (hi[8]) begin
        ctl[dbrt_pkg::BIT_FLAG_HI] = 1'b1;
        hirq = ctl[dbrt_pkg::BIT_IE_HI];
        hi   = {1'b0, high_reload};
        if (!mode16) begin
          ctl[dbrt_pkg::BIT_RUN_HIGH] = 1'b0;
        end else begin
          ctl[dbrt_pkg::BIT_FLAG_LO] = 1'b1;
          lo = {1'b0, low_reload};
        end
      end
    end

    state_nxt.ctl          = ctl;
    state_nxt.lo           = lo[7:0];
    state_nxt.hi           = hi[7:0];
    state_nxt.low_running  = lrun;
    state_nxt.high_running = hrun;

    result.low_count   = lo[7:0];
    result.high_count  = hi[7:0];
    result.control_out = ctl;
    result.low_irq     = lirq;
    result.high_irq    = hirq;
  end

endmodule

>>> hdl/dual_byte_reload_timer_top.sv
// top level of the dual byte reload timer: item register, state, result register
`timescale 1ns / 1ps
// an accepted item goes from the item register to the result register and out_ch
// throughput: one transaction per cycle while out_ch keeps taking results
// the timer state updates once per item as it leaves the item register, so the next
// item always sees the previous one's effect
// reset: synchronous active-low rst_n clears control byte, counters, running bits,
// reload registers and both valid flags

module dual_byte_reload_timer_top (
  input logic         clk,
  input logic         rst_n,
  dbrt_in_if.sink     in_ch,
  dbrt_out_if.source  out_ch,
  dbrt_cfg_if.sink    cfg_ch
);

  // item register
  dbrt_pkg::dbrt_item_t   item_r;
  logic                   item_valid_r;

  // timer state and reload registers
  dbrt_pkg::dbrt_state_t  state_r;
  dbrt_pkg::dbrt_state_t  state_nxt;
  logic [7:0]             low_reload_r;
  logic [7:0]             high_reload_r;

  // result register
  dbrt_pkg::dbrt_result_t result_r;
  dbrt_pkg::dbrt_result_t result_nxt;
  logic                   out_valid_r;

  logic                   in_fire;
  logic                   advance;

  // item moves on when the result register is free or being drained
  assign advance     = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !item_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // the user must land config writes only while idle (unenforced); always taken
  assign cfg_ch.ready = 1'b1;

  dbrt_step u_step (
    .item        (item_r),
    .state       (state_r),
    .low_reload  (low_reload_r),
    .high_reload (high_reload_r),
    .state_nxt   (state_nxt),
    .result      (result_nxt)
  );

  // item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.op             <= in_ch.op;
      item_r.write_data     <= in_ch.write_data;
      item_r.prescale_pulse <= in_ch.prescale_pulse;
    end
  end

  // timer state, committed as the item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // reload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_reload_r  <= 8'd0;
      high_reload_r <= 8'd0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        dbrt_pkg::REG_LOW_RELOAD:  low_reload_r  <= cfg_ch.data;
        dbrt_pkg::REG_HIGH_RELOAD: high_reload_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.low_count   = result_r.low_count;
  assign out_ch.high_count  = result_r.high_count;
  assign out_ch.control_out = result_r.control_out;
  assign out_ch.low_irq     = result_r.low_irq;
  assign out_ch.high_irq    = result_r.high_irq;

  // a control write leaves the counters and running bits alone
  a_write_keeps_counters: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item_r.op == dbrt_pkg::OP_WRITE) |=>
      ($stable(state_r.lo) && $stable(state_r.hi) &&
       $stable(state_r.low_running) && $stable(state_r.high_running)))
    else $error("control write disturbed timer counters");

  // interrupt pulses only with their enable bit set
  a_irq_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((!result_r.low_irq || result_r.control_out[dbrt_pkg::BIT_IE_LO]) &&
       (!result_r.high_irq || result_r.control_out[dbrt_pkg::BIT_IE_HI])))
    else $error("interrupt pulse without enable");

  // an 8-bit high overflow stops the high counter
  a_high_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.high_irq && !result_r.control_out[dbrt_pkg::BIT_MODE16]) |->
      !result_r.control_out[dbrt_pkg::BIT_RUN_HIGH])
    else $error("high run bit left set after 8-bit overflow");

  // input side only stalls behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (item_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a blocked result");

endmodule
